[sv/bfa_pkg.sv]
// Shared types, constants and sizes of the bitmap first-free allocator.
package bfa_pkg;

   // Number of allocation units the bitmap is built for; only whole bytes exist.
   localparam int BITMAP_BITS = 32768;
   localparam int MAP_BYTES   = BITMAP_BITS / 8;
   localparam int UNIT_COUNT  = MAP_BYTES * 8;

   // Widths of the bitmap memory and of internal unit numbers.
   localparam int BYTE_AW  = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
   localparam int UNIT_W   = BYTE_AW + 3;
   localparam int INDEX_W  = 15;
   localparam int REL_W    = (UNIT_W > INDEX_W) ? UNIT_W : INDEX_W;
   localparam int FREE_W   = $clog2(UNIT_COUNT + 1);

   // Fixed field widths.
   localparam int ADDR_W     = 32;
   localparam int SIZE_W     = 17;
   localparam int FREE_OUT_W = 16;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 32;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_ADDRESS = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_UNIT_SIZE    = 1'b1;

   // Reset values of the configuration registers.
   localparam logic [ADDR_W-1:0] BASE_ADDRESS_RESET = '0;
   localparam logic [SIZE_W-1:0] UNIT_SIZE_RESET    = SIZE_W'(4096);

   // Command and status codes.
   localparam logic CMD_ALLOCATE = 1'b0;
   localparam logic CMD_RELEASE  = 1'b1;
   localparam logic STATUS_DONE  = 1'b0;
   localparam logic STATUS_FULL  = 1'b1;

   typedef struct packed {
      logic               command;
      logic [INDEX_W-1:0] release_index;
   } req_type;

   typedef struct packed {
      logic                  status;
      logic [INDEX_W-1:0]    unit_index;
      logic [ADDR_W-1:0]     unit_address;
      logic [FREE_OUT_W-1:0] free_count;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_REL_RD,
      ST_REL_WR,
      ST_MUL,
      ST_DONE
   } state_type;

endpackage

[sv/bfa_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
module bfa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/bitmap_first_free_allocator_top.sv]
// Top level of the bitmap first-free allocator: sequencer, bitmap memory and result register.
//
// The block keeps one usage bit per allocation unit in a byte-wide memory and a count of free
// units. An allocate request scans the bitmap from byte zero upward, one byte per clock, takes
// the lowest clear bit of the first byte that is not full, sets it and answers with the unit
// index and base_address + unit_size * index (modulo 2^32). A release request clears the given
// bit and counts the unit free again if it was in use; an index beyond the bitmap is ignored but
// still answered. When no unit is free the allocate answers with status full, index zero and
// address zero. An allocate takes longer the higher the first byte that is not full lies, and a
// full bitmap means a scan of every byte; the scan through the single read port of the bitmap
// memory sets how long an allocate takes. A release is a read-modify-write of one byte
// followed by the address multiply. The block takes one request at a time and holds req_stall
// high until the request is done; the result then sits in an output register while the next
// request is taken. After reset the bitmap memory is cleared one byte per clock while req_stall
// stays high; configuration writes are taken at any time but should only be issued while the
// block is idle.
module bitmap_first_free_allocator_top
   import bfa_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // Request channel.
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   // Response channel.
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   // Configuration write port.
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam logic [REL_W:0]     UNIT_LIMIT = (REL_W + 1)'(UNIT_COUNT);
   localparam logic [BYTE_AW:0]   BYTE_LIMIT = (BYTE_AW + 1)'(MAP_BYTES);
   localparam logic [BYTE_AW-1:0] LAST_BYTE  = BYTE_AW'(MAP_BYTES - 1);

   // Returns the position of the lowest clear bit of a byte.
   function automatic logic [2:0] first_zero(input logic [7:0] value);
      logic [2:0] pos;
      pos = 3'd0;
      for (int k = 7; k >= 0; k--) begin
         if (!value[k]) begin
            pos = 3'(k);
         end
      end
      return pos;
   endfunction

   state_type state_ff, state_in;

   logic [BYTE_AW-1:0]    clr_ptr_ff, clr_ptr_in;
   logic [BYTE_AW:0]      scan_ptr_ff, scan_ptr_in;
   logic                  rd_pend_ff, rd_pend_in;
   logic [BYTE_AW-1:0]    rd_byte_ff, rd_byte_in;
   logic [REL_W-1:0]      found_ff, found_in;
   logic                  status_ff, status_in;
   logic [FREE_W-1:0]     free_ff, free_in;
   logic [ADDR_W-1:0]     prod_ff, prod_in;
   logic [ADDR_W-1:0]     base_ff, base_in;
   logic [SIZE_W-1:0]     size_ff, size_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   // Bitmap memory controls.
   logic                  ram_wr_en;
   logic [BYTE_AW-1:0]    ram_wr_addr;
   logic [7:0]            ram_wr_data;
   logic [BYTE_AW-1:0]    ram_rd_addr;
   logic [7:0]            ram_rd_data;

   // Decoded conditions.
   logic                  req_accept;
   logic [REL_W-1:0]      req_idx_wide;
   logic                  req_in_range;
   logic                  issue_en;
   logic                  scan_hit;
   logic                  scan_full;
   logic [2:0]            hit_bit;
   logic                  rel_bit_set;
   logic                  rsp_load;
   logic [SIZE_W+REL_W-1:0] prod_full;

   bfa_ram #(
      .WIDTH (8),
      .DEPTH (MAP_BYTES)
   ) u_bitmap (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // The block is only open for a new request in the idle state.
   assign req_stall    = (state_ff != ST_IDLE);
   assign req_accept   = req_valid && !req_stall;
   assign req_idx_wide = REL_W'(req_data.release_index);
   assign req_in_range = ({1'b0, req_idx_wide} < UNIT_LIMIT);

   // The scan issues one byte read per clock and checks each returned byte in the following clock.
   assign issue_en  = (state_ff == ST_SCAN) && (scan_ptr_ff < BYTE_LIMIT);
   assign scan_hit  = (state_ff == ST_SCAN) && rd_pend_ff && (ram_rd_data != 8'hFF);
   assign scan_full = (state_ff == ST_SCAN) && rd_pend_ff && (ram_rd_data == 8'hFF)
                      && (rd_byte_ff == LAST_BYTE);
   assign hit_bit   = first_zero(ram_rd_data);

   // During a release the held unit number selects the bit within the byte just read.
   assign rel_bit_set = ram_rd_data[found_ff[2:0]];

   // A finished result moves to the output register once that register is free.
   assign rsp_load = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);

   // The single multiplier scales the unit number by the unit size.
   assign prod_full = size_ff * found_ff;

   // Next-state logic of the sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ptr_ff == LAST_BYTE) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               if (req_data.command == CMD_RELEASE) begin
                  state_in = req_in_range ? ST_REL_RD : ST_MUL;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (scan_hit) begin
               state_in = ST_MUL;
            end else if (scan_full) begin
               state_in = ST_DONE;
            end
         end
         ST_REL_RD: begin
            state_in = ST_REL_WR;
         end
         ST_REL_WR: begin
            state_in = ST_MUL;
         end
         ST_MUL: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // Datapath and memory controls for each state.
   always_comb begin
      clr_ptr_in   = clr_ptr_ff;
      scan_ptr_in  = scan_ptr_ff;
      rd_pend_in   = 1'b0;
      rd_byte_in   = rd_byte_ff;
      found_in     = found_ff;
      status_in    = status_ff;
      free_in      = free_ff;
      prod_in      = prod_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = clr_ptr_ff;
      ram_wr_data  = 8'h00;
      ram_rd_addr  = scan_ptr_ff[BYTE_AW-1:0];

      case (state_ff)
         ST_CLEAR: begin
            // Zero one byte per clock until the whole bitmap is free.
            ram_wr_en  = 1'b1;
            clr_ptr_in = clr_ptr_ff + 1'b1;
         end
         ST_IDLE: begin
            if (req_accept) begin
               scan_ptr_in = '0;
               status_in   = STATUS_DONE;
               found_in    = req_idx_wide;
            end
         end
         ST_SCAN: begin
            if (issue_en) begin
               scan_ptr_in = scan_ptr_ff + 1'b1;
               rd_byte_in  = scan_ptr_ff[BYTE_AW-1:0];
               rd_pend_in  = !scan_hit;
            end
            if (scan_hit) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = rd_byte_ff;
               ram_wr_data = ram_rd_data | (8'h01 << hit_bit);
               found_in    = REL_W'({rd_byte_ff, hit_bit});
               free_in     = free_ff - 1'b1;
            end else if (scan_full) begin
               status_in = STATUS_FULL;
               found_in  = '0;
            end
         end
         ST_REL_RD: begin
            ram_rd_addr = found_ff[3 +: BYTE_AW];
         end
         ST_REL_WR: begin
            ram_wr_addr = found_ff[3 +: BYTE_AW];
            ram_wr_data = ram_rd_data & ~(8'h01 << found_ff[2:0]);
            if (rel_bit_set) begin
               ram_wr_en = 1'b1;
               free_in   = free_ff + 1'b1;
            end
         end
         ST_MUL: begin
            prod_in = ADDR_W'(prod_full);
         end
         ST_DONE: begin
         end
         default: begin
         end
      endcase
   end

   // Configuration registers.
   always_comb begin
      base_in = base_ff;
      size_in = size_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_BASE_ADDRESS: base_in = ADDR_W'(csr_wdata);
            CSR_UNIT_SIZE:    size_in = SIZE_W'(csr_wdata);
            default: begin
            end
         endcase
      end
   end

   // Output register; the address add happens on the way in.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (rsp_load) begin
         rsp_valid_in              = 1'b1;
         rsp_data_in.status        = status_ff;
         rsp_data_in.unit_index    = INDEX_W'(found_ff);
         rsp_data_in.unit_address  = (status_ff == STATUS_FULL) ? '0 : (base_ff + prod_ff);
         rsp_data_in.free_count    = FREE_OUT_W'(free_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ptr_ff   <= '0;
         rd_pend_ff   <= 1'b0;
         free_ff      <= FREE_W'(UNIT_COUNT);
         base_ff      <= BASE_ADDRESS_RESET;
         size_ff      <= UNIT_SIZE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ptr_ff   <= clr_ptr_in;
         rd_pend_ff   <= rd_pend_in;
         free_ff      <= free_in;
         base_ff      <= base_in;
         size_ff      <= size_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ptr_ff <= scan_ptr_in;
      rd_byte_ff  <= rd_byte_in;
      found_ff    <= found_in;
      status_ff   <= status_in;
      prod_ff     <= prod_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // The free count never exceeds the number of units in the bitmap.
   assert property (@(posedge clock) disable iff (reset)
      free_ff <= FREE_W'(UNIT_COUNT))
      else $error("free count above unit count");

   // A full answer is only given when no unit is free.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_load && (status_ff == STATUS_FULL)) |-> (free_ff == '0))
      else $error("full status with free units left");

   // Taking a unit in the scan lowers the free count by exactly one.
   assert property (@(posedge clock) disable iff (reset)
      scan_hit |=> (free_ff == FREE_W'($past(free_ff) - 1'b1)))
      else $error("allocation did not decrement free count");

   // An accepted request always leaves the idle state.
   assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff != ST_IDLE))
      else $error("accepted request did not start");

   // The scan never checks a byte that was not read for it.
   assert property (@(posedge clock) disable iff (reset)
      rd_pend_ff |-> (state_ff == ST_SCAN))
      else $error("pending scan read outside the scan");

endmodule

[bench/unit_ledger_pkg.sv]
`timescale 1ns / 100ps
// Bookkeeping class that predicts and checks the allocator's responses.
package unit_ledger_pkg;
   import bfa_pkg::*;

   class unit_ledger;
      logic [7:0]        map_bytes [MAP_BYTES];
      int unsigned       free_units;
      logic [ADDR_W-1:0] base_address;
      logic [SIZE_W-1:0] unit_size;
      // One past the highest unit handed out so far; steers releases toward busy units.
      int unsigned       high_water;
      rsp_type           due_replies [$];
      int unsigned       replies_seen;
      int unsigned       mismatches;

      function new();
         foreach (map_bytes[b]) map_bytes[b] = 8'h00;
         free_units   = UNIT_COUNT;
         base_address = BASE_ADDRESS_RESET;
         unit_size    = UNIT_SIZE_RESET;
         high_water   = 0;
         replies_seen = 0;
         mismatches   = 0;
      endfunction

      function void set_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            CSR_BASE_ADDRESS: base_address = value[ADDR_W-1:0];
            CSR_UNIT_SIZE:    unit_size    = value[SIZE_W-1:0];
            default: ;
         endcase
      endfunction

      // The product is taken at address width, so it wraps like the hardware.
      function logic [ADDR_W-1:0] address_of(int unsigned unit);
         logic [ADDR_W-1:0] scaled;
         scaled = unit_size * unit;
         return base_address + scaled;
      endfunction

      function void log_request(req_type r);
         rsp_type     reply;
         int unsigned b;
         int unsigned k;
         int unsigned unit;
         bit          hit;
         reply        = '0;
         reply.status = STATUS_DONE;
         unit         = 0;
         if (r.command == CMD_ALLOCATE) begin
            hit = 1'b0;
            for (b = 0; b < MAP_BYTES && !hit; b++) begin
               if (map_bytes[b] != 8'hFF) begin
                  for (k = 0; k < 8 && !hit; k++) begin
                     if (!map_bytes[b][k]) begin
                        map_bytes[b][k] = 1'b1;
                        unit = b * 8 + k;
                        hit  = 1'b1;
                     end
                  end
               end
            end
            if (hit) begin
               free_units--;
               reply.unit_index   = INDEX_W'(unit);
               reply.unit_address = address_of(unit);
               if (unit + 1 > high_water) high_water = unit + 1;
            end else begin
               reply.status = STATUS_FULL;
            end
         end else begin
            unit               = r.release_index;
            reply.unit_index   = r.release_index;
            reply.unit_address = address_of(unit);
            if (unit < UNIT_COUNT && map_bytes[unit / 8][unit % 8]) begin
               map_bytes[unit / 8][unit % 8] = 1'b0;
               free_units++;
            end
         end
         reply.free_count = FREE_OUT_W'(free_units);
         due_replies.push_back(reply);
      endfunction

      task report(string what);
         $display("ERROR: %s", what);
         mismatches++;
      endtask

      task check_reply(rsp_type got);
         rsp_type want;
         replies_seen++;
         if (due_replies.size() == 0) begin
            report($sformatf("response %0d arrived with no request outstanding", replies_seen));
            return;
         end
         want = due_replies.pop_front();
         if (got.status !== want.status || got.unit_index !== want.unit_index ||
             got.unit_address !== want.unit_address || got.free_count !== want.free_count) begin
            report($sformatf(
               "response %0d: status %0d index %0d address %h free %0d, wanted %0d %0d %h %0d",
               replies_seen, got.status, got.unit_index, got.unit_address, got.free_count,
               want.status, want.unit_index, want.unit_address, want.free_count));
         end
      endtask
   endclass

endpackage

[bench/tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench of the bitmap first-free allocator top level.
module tb;
   import bfa_pkg::*;
   import unit_ledger_pkg::*;

   // Each side idles in about this many cycles of a hundred.
   localparam int IDLE_PERCENT     = 13;
   // Length of the one long receiver hold-off that backs the block up.
   localparam int HOLD_OFF_CYCLES  = 300;
   localparam int RANDOM_PER_PHASE = 25;
   // Quiet time after the last response, long enough for a stray one to show up.
   localparam int DRAIN_CYCLES     = 64;
   // The clearing pass after reset and a scan of the whole bitmap both run with nothing
   // accepted, so the limit leaves room for both and for the long receiver hold-off.
   localparam int WATCHDOG_LIMIT   = 4 * (MAP_BYTES + HOLD_OFF_CYCLES + 64);

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_BASE_ADDRESS;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   unit_ledger  ledger = new();
   // When set, neither side idles, giving a stretch of back-to-back traffic.
   bit          steady_flow = 1'b0;
   // The main sequence bumps this to ask the receiver for one long hold-off.
   int unsigned hold_offs_asked = 0;
   int unsigned quiet_cycles = 0;

   bitmap_first_free_allocator_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Everything is sampled at the rising edge, before the edge's own updates land, so
   // the monitor sees exactly the handshakes that the block sees. The response is
   // checked before the new request is logged; a response always belongs to an older
   // request, so the order only keeps the queue easy to follow.
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) ledger.check_reply(rsp_data);
         if (req_valid && !req_stall) ledger.log_request(req_data);
         if (csr_we) ledger.set_register(csr_index, csr_wdata);
         if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall)) begin
            quiet_cycles <= 0;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // A run that stops moving for too long has lost a request or a response.
   initial begin
      while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("bitmap_first_free_allocator_top: mismatch");
      $finish;
   end

   // The receiver stalls at random, except during the steady stretch. On request it
   // holds off for a long, fixed number of cycles so that a result parks in the
   // output register, the next request completes behind it and req_stall stays high.
   initial begin
      int unsigned served;
      served = 0;
      forever begin
         @(posedge clock);
         if (hold_offs_asked != served) begin
            served++;
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end
         rsp_stall <= !steady_flow && ($urandom_range(99) < IDLE_PERCENT);
      end
   end

   function automatic req_type request_of(logic command, logic [INDEX_W-1:0] index);
      req_type r;
      r.command       = command;
      r.release_index = index;
      return r;
   endfunction

   // Most traffic is allocations and releases of units that are likely in use, so
   // the bitmap stays dense near the bottom and releases really free something. The
   // rest releases arbitrary units, nearly all of which are already free.
   function automatic req_type random_request();
      req_type     r;
      int unsigned pick;
      pick            = $urandom_range(99);
      r.release_index = INDEX_W'($urandom);
      if (pick < 45) begin
         r.command = CMD_ALLOCATE;
      end else begin
         r.command = CMD_RELEASE;
         if (pick < 82 && ledger.high_water != 0) begin
            r.release_index = INDEX_W'($urandom_range(ledger.high_water - 1));
         end
      end
      return r;
   endfunction

   // Offers one request and returns at the edge where it is taken. Valid is only
   // lowered for an idle gap, so it is never dropped and raised in one step.
   task automatic offer_request(input req_type r);
      while (!steady_flow && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Lets one edge pass so the monitor has logged the last request, then waits
   // until every response it predicted has come back.
   task automatic drain_replies();
      req_valid <= 1'b0;
      do @(posedge clock); while (ledger.due_replies.size() != 0);
   endtask

   // Writes both registers on consecutive edges; the block is idle whenever this runs.
   task automatic set_unit_layout(input logic [CSR_DATA_W-1:0] base,
                                  input logic [CSR_DATA_W-1:0] size_word);
      csr_we    <= 1'b1;
      csr_index <= CSR_BASE_ADDRESS;
      csr_wdata <= base;
      @(posedge clock);
      csr_index <= CSR_UNIT_SIZE;
      csr_wdata <= size_word;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic run_phase(input logic [CSR_DATA_W-1:0] base,
                            input logic [CSR_DATA_W-1:0] size_word,
                            input bit pressure, input bit steady);
      set_unit_layout(base, size_word);
      steady_flow = steady;
      if (pressure) hold_offs_asked++;
      repeat (RANDOM_PER_PHASE) offer_request(random_request());
      drain_replies();
      steady_flow = 1'b0;
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed part at the reset layout. The first allocations come out in order;
      // releasing unit 0 twice shows that only a unit in use is counted free again;
      // the next allocation refills the lowest hole.
      repeat (2) offer_request(request_of(CMD_ALLOCATE, '0));
      offer_request(request_of(CMD_RELEASE, INDEX_W'(0)));
      offer_request(request_of(CMD_RELEASE, INDEX_W'(0)));
      offer_request(request_of(CMD_ALLOCATE, '1));
      // Fill byte zero and spill into byte one, so the scan has to step past a full byte.
      repeat (8) offer_request(request_of(CMD_ALLOCATE, '0));
      // A hole in the middle of a full byte is the first free unit.
      offer_request(request_of(CMD_RELEASE, INDEX_W'(5)));
      offer_request(request_of(CMD_ALLOCATE, '0));
      // Releases of units that are already free, at the top index and with alternating
      // bit patterns, answer with their own address and change nothing; unit 9 is in use and freed.
      offer_request(request_of(CMD_RELEASE, '1));
      offer_request(request_of(CMD_RELEASE, INDEX_W'(15'h5555)));
      offer_request(request_of(CMD_RELEASE, INDEX_W'(15'h2AAA)));
      offer_request(request_of(CMD_RELEASE, INDEX_W'(9)));
      offer_request(request_of(CMD_ALLOCATE, INDEX_W'(15'h7FFF)));
      drain_replies();

      // Random phases over a range of layouts: the largest base with a unit size of one
      // so addresses wrap, a unit size of 65536, every bit of the write data set,
      // a unit size of zero, and a random layout during the steady stretch. The
      // long receiver hold-off falls in the third phase.
      run_phase(32'hFFFF_FFFF, 32'd1, 1'b0, 1'b0);
      run_phase(32'h0000_0000, 32'd65536, 1'b0, 1'b0);
      run_phase($urandom, 32'hFFFF_FFFF, 1'b1, 1'b0);
      run_phase($urandom, 32'd0, 1'b0, 1'b0);
      run_phase($urandom, $urandom_range(1, 65536), 1'b0, 1'b1);

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (ledger.mismatches == 0 && ledger.due_replies.size() == 0) begin
         $display("bitmap_first_free_allocator_top: match");
      end else begin
         $display("bitmap_first_free_allocator_top: mismatch");
      end
      $finish;
   end

endmodule

[bitmap_first_free_allocator_top.f]
sv/bfa_pkg.sv
sv/bfa_ram.sv
sv/bitmap_first_free_allocator_top.sv
bench/unit_ledger_pkg.sv
bench/tb.sv
